### rtl/cpd_pkg.sv
// Shared types, constants and codes for the coalescent prior delta block.
`default_nettype none

package cpd_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_DATE_WIDTH  = 48;

    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int ALPHA_W   = 48;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int RES_W     = 64;
    localparam int FRAC_W    = 16;

    // quotient bits produced by the serial divider
    localparam int DIV_BITS  = RES_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(65536);

    localparam logic [1:0] MODE_WR_LEAF = 2'd0;
    localparam logic [1:0] MODE_WR_NODE = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SCALE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK,
        ST_EQ,
        ST_SRD,
        ST_SCMP,
        ST_WRD,
        ST_WEV,
        ST_MUL,
        ST_PROD,
        ST_ACC,
        ST_COMPL,
        ST_DINIT,
        ST_DSTEP,
        ST_DOUT
    } cpd_state_t;

    typedef struct packed {
        logic wr_leaf;
        logic wr_node;
        logic load;
        logic kinit;
        logic srch_rd;
        logic srch_cmp;
        logic walk_ev;
        logic mul;
        logic prod;
        logic acc;
        logic compl_form;
        logic dinit;
        logic dstep;
        logic dout;
        logic eq_out;
    } cpd_cmd_t;

    typedef struct packed {
        logic dates_eq;
        logic srch_done;
        logic last;
        logic div_last;
    } cpd_stat_t;

endpackage

`default_nettype wire

### rtl/cpd_ctrl.sv
// Controller state machine for the coalescent prior delta block.
`default_nettype none

module cpd_ctrl
    import cpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] mode,
    input  wire cpd_stat_t  stat,
    output cpd_cmd_t        cmd,
    output logic            busy,
    output logic            done
);

    cpd_state_t state_reg;
    cpd_state_t state_next;
    logic       done_reg;
    logic       done_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_QUERY))
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.dates_eq)
                    state_next = ST_EQ;
                else if (stat.srch_done)
                    state_next = ST_WRD;
                else
                    state_next = ST_SRD;
            end
            ST_EQ:    state_next = ST_IDLE;
            ST_SRD:   state_next = ST_SCMP;
            ST_SCMP:  state_next = ST_CHK;
            ST_WRD:   state_next = ST_WEV;
            ST_WEV:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_ACC;
            ST_ACC:   state_next = stat.last ? ST_COMPL : ST_WRD;
            ST_COMPL: state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DSTEP;
            ST_DSTEP:
            begin
                if (stat.div_last)
                    state_next = ST_DOUT;
            end
            ST_DOUT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.wr_leaf    = accept && (mode == MODE_WR_LEAF);
        cmd.wr_node    = accept && (mode == MODE_WR_NODE);
        cmd.load       = accept && (mode == MODE_QUERY);
        cmd.kinit      = (state_reg == ST_CHK);
        cmd.srch_rd    = (state_reg == ST_SRD);
        cmd.srch_cmp   = (state_reg == ST_SCMP);
        cmd.walk_ev    = (state_reg == ST_WEV);
        cmd.mul        = (state_reg == ST_MUL);
        cmd.prod       = (state_reg == ST_PROD);
        cmd.acc        = (state_reg == ST_ACC);
        cmd.compl_form = (state_reg == ST_COMPL);
        cmd.dinit      = (state_reg == ST_DINIT);
        cmd.dstep      = (state_reg == ST_DSTEP);
        cmd.dout       = (state_reg == ST_DOUT);
        cmd.eq_out     = (state_reg == ST_EQ);
        busy           = (state_reg != ST_IDLE);
        done_next      = (state_reg == ST_DOUT) || (state_reg == ST_EQ);
        done           = done_reg;
    end

endmodule

`default_nettype wire

### rtl/cpd_dp.sv
// Datapath: date tables, search and merge registers, multiplier and serial divider.
`default_nettype none

module cpd_dp
    import cpd_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int DATE_WIDTH  = DEF_DATE_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cpd_cmd_t              cmd,
    output cpd_stat_t                  stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [IDX_W-1:0]      entry_index,
    input  wire logic [DATE_WIDTH-1:0] entry_date,
    input  wire logic [DATE_WIDTH-1:0] old_date,
    input  wire logic [DATE_WIDTH-1:0] new_date,
    output logic [RES_W-1:0]           prior_delta,
    output logic                       saturated
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int KW  = CW + 1;
    localparam int DW1 = DATE_WIDTH + 1;
    localparam int PLW = KW + 33;
    localparam int PHW = KW + 32;
    localparam int PW  = KW + 65;
    localparam logic signed [PW-1:0] P_MAX = PW'(65'sh0_7fff_ffff_ffff_ffff);
    localparam logic signed [RES_W-1:0] R_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [RES_W-1:0] R_MIN = 64'sh8000_0000_0000_0000;

    logic [DATE_WIDTH-1:0] leaf_mem [MAX_ENTRIES];
    logic [DATE_WIDTH-1:0] node_mem [MAX_ENTRIES];
    logic [DATE_WIDTH-1:0] leaf_rd_reg;
    logic [DATE_WIDTH-1:0] node_rd_reg;

    logic [CNT_W-1:0]   leaf_count_reg;
    logic [CNT_W-1:0]   node_count_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    logic signed [DATE_WIDTH-1:0] lo_reg, lo_next;
    logic signed [DATE_WIDTH-1:0] hi_reg, hi_next;
    logic signed [DATE_WIDTH-1:0] prev_reg, prev_next;
    logic signed [DATE_WIDTH-1:0] e_reg, e_next;
    logic signed [DW1-1:0]        d_reg, d_next;
    logic                         younger_reg, younger_next;
    logic                         eq_reg, eq_next;
    logic                         take_reg, take_next;
    logic                         last_reg, last_next;
    logic [CW-1:0]                nl_reg, nl_next;
    logic [CW-1:0]                nn_reg, nn_next;
    logic [CW-1:0]                l_lo_reg, l_lo_next;
    logic [CW-1:0]                l_hi_reg, l_hi_next;
    logic [CW-1:0]                n_lo_reg, n_lo_next;
    logic [CW-1:0]                n_hi_reg, n_hi_next;
    logic signed [KW-1:0]         k_reg, k_next;
    logic signed [PLW-1:0]        pl_reg, pl_next;
    logic signed [PHW-1:0]        ph_reg, ph_next;
    logic signed [RES_W-1:0]      m_reg, m_next;
    logic signed [RES_W-1:0]      sum_reg, sum_next;
    logic                         clip_reg, clip_next;
    logic                         neg_reg, neg_next;
    logic [DIV_BITS-1:0]          num_reg, num_next;
    logic [ALPHA_W-1:0]           rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]         dcnt_reg, dcnt_next;
    logic [RES_W-1:0]             res_reg, res_next;
    logic                         sat_reg, sat_next;

    logic [31:0]           idx_wide;
    logic                  wr_ok;
    logic [AW-1:0]         wr_addr;
    logic [CW-1:0]         nl_eff, nn_eff;
    logic [CW:0]           lmid_sum, nmid_sum;
    logic [CW-1:0]         lmid, nmid;
    logic [AW-1:0]         leaf_addr, node_addr;
    logic                  l_act, n_act;
    logic signed [DATE_WIDTH-1:0] el, en, e_sel;
    logic                  hl, hn, take_leaf, walk_end;
    logic signed [RES_W-1:0] d64;
    logic signed [PW-1:0]  prod;
    logic                  pclip;
    logic signed [RES_W:0] s65;
    logic [ALPHA_W-1:0]    alpha_eff;
    logic [ALPHA_W:0]      trial;
    logic                  qbit;
    logic [RES_W-1:0]      mag;
    logic                  qclip;
    logic [RES_W-1:0]      qmag;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= '0;
            node_count_reg <= '0;
            alpha_reg      <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEAF_COUNT:  leaf_count_reg <= cfg_data[CNT_W-1:0];
                REG_NODE_COUNT:  node_count_reg <= cfg_data[CNT_W-1:0];
                REG_ALPHA_SCALE: alpha_reg      <= cfg_data[ALPHA_W-1:0];
                default:         ;
            endcase
        end
    end

    assign idx_wide = 32'(entry_index);
    assign wr_ok    = idx_wide < 32'(MAX_ENTRIES);
    assign wr_addr  = idx_wide[AW-1:0];

    assign nl_eff = (32'(leaf_count_reg) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                             : CW'(leaf_count_reg);
    assign nn_eff = (32'(node_count_reg) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                             : CW'(node_count_reg);

    assign lmid_sum = {1'b0, l_lo_reg} + {1'b0, l_hi_reg};
    assign nmid_sum = {1'b0, n_lo_reg} + {1'b0, n_hi_reg};
    assign lmid     = lmid_sum[CW:1];
    assign nmid     = nmid_sum[CW:1];
    assign leaf_addr = cmd.srch_rd ? lmid[AW-1:0] : l_lo_reg[AW-1:0];
    assign node_addr = cmd.srch_rd ? nmid[AW-1:0] : n_lo_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_leaf && wr_ok)
            leaf_mem[wr_addr] <= entry_date;
        if (cmd.wr_node && wr_ok)
            node_mem[wr_addr] <= entry_date;
        leaf_rd_reg <= leaf_mem[leaf_addr];
        node_rd_reg <= node_mem[node_addr];
    end

    assign l_act = l_lo_reg < l_hi_reg;
    assign n_act = n_lo_reg < n_hi_reg;

    // merge step: pick the next event, leaf first on a tie
    assign el        = $signed(leaf_rd_reg);
    assign en        = $signed(node_rd_reg);
    assign hl        = l_lo_reg < nl_reg;
    assign hn        = n_lo_reg < nn_reg;
    assign take_leaf = hl && (!hn || (el >= en));
    assign e_sel     = take_leaf ? el : en;
    assign walk_end  = (!hl && !hn) || !(e_sel > lo_reg);

    assign d64   = RES_W'(d_reg);
    assign prod  = (PW'(ph_reg) <<< 32) + PW'(pl_reg);
    assign pclip = (prod > P_MAX) || (prod < -P_MAX);

    assign alpha_eff = (alpha_reg == '0) ? ALPHA_W'(1) : alpha_reg;
    assign trial     = {rem_reg, num_reg[DIV_BITS-1]};
    assign qbit      = trial >= {1'b0, alpha_eff};
    assign mag       = sum_reg[RES_W-1] ? (RES_W'(0) - sum_reg) : sum_reg;
    assign qclip     = |num_reg[DIV_BITS-1:RES_W-1];
    assign qmag      = {1'b0, num_reg[RES_W-2:0]};

    always_comb
    begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        prev_next    = prev_reg;
        e_next       = e_reg;
        d_next       = d_reg;
        younger_next = younger_reg;
        eq_next      = eq_reg;
        take_next    = take_reg;
        last_next    = last_reg;
        nl_next      = nl_reg;
        nn_next      = nn_reg;
        l_lo_next    = l_lo_reg;
        l_hi_next    = l_hi_reg;
        n_lo_next    = n_lo_reg;
        n_hi_next    = n_hi_reg;
        k_next       = k_reg;
        pl_next      = pl_reg;
        ph_next      = ph_reg;
        m_next       = m_reg;
        sum_next     = sum_reg;
        clip_next    = clip_reg;
        neg_next     = neg_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        res_next     = res_reg;
        sat_next     = sat_reg;
        s65          = '0;

        if (cmd.load)
        begin
            lo_next      = ($signed(old_date) < $signed(new_date)) ? old_date : new_date;
            hi_next      = ($signed(old_date) < $signed(new_date)) ? new_date : old_date;
            younger_next = $signed(new_date) < $signed(old_date);
            eq_next      = old_date == new_date;
            nl_next      = nl_eff;
            nn_next      = nn_eff;
            l_lo_next    = '0;
            l_hi_next    = nl_eff;
            n_lo_next    = '0;
            n_hi_next    = nn_eff;
            sum_next     = '0;
            clip_next    = 1'b0;
        end

        if (cmd.kinit)
        begin
            k_next    = $signed({1'b0, l_lo_reg}) - $signed({1'b0, n_lo_reg});
            prev_next = hi_reg;
        end

        if (cmd.srch_cmp)
        begin
            if (l_act)
            begin
                if (el >= hi_reg)
                    l_lo_next = lmid + 1'b1;
                else
                    l_hi_next = lmid;
            end
            if (n_act)
            begin
                if (en >= hi_reg)
                    n_lo_next = nmid + 1'b1;
                else
                    n_hi_next = nmid;
            end
        end

        if (cmd.walk_ev)
        begin
            take_next = take_leaf;
            e_next    = e_sel;
            last_next = walk_end;
            d_next    = walk_end ? (DW1'(prev_reg) - DW1'(lo_reg))
                                 : (DW1'(prev_reg) - DW1'(e_sel));
        end

        // split the 64-bit interval so each product stays near 32 bits
        if (cmd.mul)
        begin
            pl_next = PLW'(k_reg) * PLW'($signed({1'b0, d64[31:0]}));
            ph_next = PHW'(k_reg) * PHW'($signed(d64[63:32]));
        end

        if (cmd.prod)
        begin
            if (pclip)
            begin
                m_next    = prod[PW-1] ? R_MIN : R_MAX;
                clip_next = 1'b1;
            end
            else
                m_next = prod[RES_W-1:0];
        end

        if (cmd.acc)
        begin
            s65 = {sum_reg[RES_W-1], sum_reg} + {m_reg[RES_W-1], m_reg};
            if (s65[RES_W] != s65[RES_W-1])
            begin
                sum_next  = s65[RES_W] ? R_MIN : R_MAX;
                clip_next = 1'b1;
            end
            else
                sum_next = s65[RES_W-1:0];
            if (!last_reg)
            begin
                if (take_reg)
                begin
                    k_next    = k_reg + KW'(1);
                    l_lo_next = l_lo_reg + 1'b1;
                end
                else
                begin
                    k_next    = k_reg - KW'(1);
                    n_lo_next = n_lo_reg + 1'b1;
                end
                prev_next = e_reg;
            end
        end

        // date moved younger: use the complement of the interval sum
        if (cmd.compl_form && younger_reg)
        begin
            s65 = (RES_W+1)'(DW1'(hi_reg) - DW1'(lo_reg)) - {sum_reg[RES_W-1], sum_reg};
            if (s65[RES_W] != s65[RES_W-1])
            begin
                sum_next  = s65[RES_W] ? R_MIN : R_MAX;
                clip_next = 1'b1;
            end
            else
                sum_next = s65[RES_W-1:0];
        end

        if (cmd.dinit)
        begin
            neg_next  = sum_reg[RES_W-1];
            num_next  = {mag, FRAC_W'(0)};
            rem_next  = '0;
            dcnt_next = DIV_CNT_W'(DIV_BITS);
        end

        if (cmd.dstep)
        begin
            rem_next  = qbit ? ALPHA_W'(trial - {1'b0, alpha_eff}) : trial[ALPHA_W-1:0];
            num_next  = {num_reg[DIV_BITS-2:0], qbit};
            dcnt_next = dcnt_reg - 1'b1;
        end

        if (cmd.dout)
        begin
            if (qclip)
                res_next = neg_reg ? R_MIN : R_MAX;
            else
                res_next = neg_reg ? (RES_W'(0) - qmag) : qmag;
            sat_next = clip_reg || qclip;
        end

        if (cmd.eq_out)
        begin
            res_next = '0;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg      <= '0;
            hi_reg      <= '0;
            prev_reg    <= '0;
            e_reg       <= '0;
            d_reg       <= '0;
            younger_reg <= 1'b0;
            eq_reg      <= 1'b0;
            take_reg    <= 1'b0;
            last_reg    <= 1'b0;
            nl_reg      <= '0;
            nn_reg      <= '0;
            l_lo_reg    <= '0;
            l_hi_reg    <= '0;
            n_lo_reg    <= '0;
            n_hi_reg    <= '0;
            k_reg       <= '0;
            pl_reg      <= '0;
            ph_reg      <= '0;
            m_reg       <= '0;
            sum_reg     <= '0;
            clip_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            num_reg     <= '0;
            rem_reg     <= '0;
            dcnt_reg    <= '0;
            res_reg     <= '0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            prev_reg    <= prev_next;
            e_reg       <= e_next;
            d_reg       <= d_next;
            younger_reg <= younger_next;
            eq_reg      <= eq_next;
            take_reg    <= take_next;
            last_reg    <= last_next;
            nl_reg      <= nl_next;
            nn_reg      <= nn_next;
            l_lo_reg    <= l_lo_next;
            l_hi_reg    <= l_hi_next;
            n_lo_reg    <= n_lo_next;
            n_hi_reg    <= n_hi_next;
            k_reg       <= k_next;
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            m_reg       <= m_next;
            sum_reg     <= sum_next;
            clip_reg    <= clip_next;
            neg_reg     <= neg_next;
            num_reg     <= num_next;
            rem_reg     <= rem_next;
            dcnt_reg    <= dcnt_next;
            res_reg     <= res_next;
            sat_reg     <= sat_next;
        end
    end

    assign stat.dates_eq  = eq_reg;
    assign stat.srch_done = !l_act && !n_act;
    assign stat.last      = last_reg;
    assign stat.div_last  = (dcnt_reg == DIV_CNT_W'(1));

    assign prior_delta = res_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

### rtl/coalescent_prior_delta_top.sv
// Top level of the coalescent prior delta block: controller plus datapath.
// Table writes and unused modes end at the accepting edge; busy stays low.
// Query with equal dates: the controller steps through ST_CHK and ST_EQ; done is registered.
// Other queries: a binary search of both tables (up to 11 steps at 1024 entries), a merge step (ST_WRD to ST_ACC)
// per event crossed and one for the closing interval, then the serial divide and ST_DOUT.
// One query at a time; done cannot be stalled; async reset clears control, not tables.
`default_nettype none

module coalescent_prior_delta_top
    import cpd_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int DATE_WIDTH  = DEF_DATE_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    output logic                       done,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic [1:0]            mode,
    input  wire logic [IDX_W-1:0]      entry_index,
    input  wire logic [DATE_WIDTH-1:0] entry_date,
    input  wire logic [DATE_WIDTH-1:0] old_date,
    input  wire logic [DATE_WIDTH-1:0] new_date,
    output logic [RES_W-1:0]           prior_delta,
    output logic                       saturated
);

    cpd_cmd_t  cmd;
    cpd_stat_t stat;

    cpd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    cpd_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATE_WIDTH  (DATE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .entry_date  (entry_date),
        .old_date    (old_date),
        .new_date    (new_date),
        .prior_delta (prior_delta),
        .saturated   (saturated)
    );

endmodule

`default_nettype wire

### rtl/cpd_checker.sv
// Port-level assertions for the coalescent prior delta block and their bind.
`default_nettype none

module cpd_checker
    import cpd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [1:0] mode
);

    a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_QUERY)) |=> busy)
        else $error("query accepted but block not busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result word without a query in flight");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word repeated");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode != MODE_QUERY)) |=> (!done && !busy))
        else $error("table write produced a result or went busy");

endmodule

bind coalescent_prior_delta_top cpd_checker u_cpd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .mode  (mode)
);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the coalescent prior delta block.
`timescale 1ns / 1ps

module testbench;
    import cpd_pkg::*;

    localparam int  ENTRIES    = 1024;
    localparam int  NODE_FILL  = 24;
    localparam int  CYCLE_CAP  = 3000000;
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    typedef logic signed [DEF_DATE_WIDTH-1:0] date_t;

    typedef struct {
        longint delta;
        bit     sat;
    } delta_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      done;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic [1:0]                mode;
    logic [IDX_W-1:0]          entry_index;
    logic [DEF_DATE_WIDTH-1:0] entry_date;
    logic [DEF_DATE_WIDTH-1:0] old_date;
    logic [DEF_DATE_WIDTH-1:0] new_date;
    logic [RES_W-1:0]          prior_delta;
    logic                      saturated;

    // shadow of the block state
    date_t        leaf_mem [ENTRIES];
    date_t        node_mem [ENTRIES];
    logic [10:0]  leaf_cnt;
    logic [10:0]  node_cnt;
    logic [47:0]  alpha_val;
    bit           clip;

    delta_word_t  delta_q [$];
    int           gap_pct;
    int           errors;
    int           cycles;
    int           sent;

    coalescent_prior_delta_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .entry_index (entry_index),
        .entry_date  (entry_date),
        .old_date    (old_date),
        .new_date    (new_date),
        .prior_delta (prior_delta),
        .saturated   (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic longint add_clip(longint a, longint b);
        longint r;
        r = a + b;
        if (a >= 0 && b >= 0 && r < 0)
        begin
            clip = 1'b1;
            return I64_MAX;
        end
        if (a < 0 && b < 0 && r >= 0)
        begin
            clip = 1'b1;
            return I64_MIN;
        end
        return r;
    endfunction

    function automatic longint sub_clip(longint a, longint b);
        if (b < 0 && a > I64_MAX + b)
        begin
            clip = 1'b1;
            return I64_MAX;
        end
        if (b > 0 && a < I64_MIN + b)
        begin
            clip = 1'b1;
            return I64_MIN;
        end
        return a - b;
    endfunction

    function automatic longint mul_clip(longint k, longint d);
        longint ak;
        longint lim;
        if (k == 0 || d == 0)
            return 0;
        ak  = (k < 0) ? -k : k;
        lim = I64_MAX / ak;
        if (d > lim || d < -lim)
        begin
            clip = 1'b1;
            return ((k < 0) != (d < 0)) ? I64_MIN : I64_MAX;
        end
        return k * d;
    endfunction

    function automatic int eff_cnt(logic [10:0] c);
        return (c > ENTRIES) ? ENTRIES : int'(c);
    endfunction

    function automatic int count_ge(bit leaf_side, int n, longint x);
        int lo;
        int hi;
        int mid;
        longint v;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            v = leaf_side ? longint'(leaf_mem[mid]) : longint'(node_mem[mid]);
            if (v >= x)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic longint scale_by_alpha(longint num);
        logic [63:0] a;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        bit neg;
        a = {16'd0, alpha_val};
        if (a == 0)
            a = 1;
        neg = num < 0;
        mag = neg ? 64'd0 - 64'(num) : 64'(num);
        q = mag / a;
        r = mag % a;
        if (q >= (64'd1 << 47))
        begin
            clip = 1'b1;
            return neg ? I64_MIN : I64_MAX;
        end
        m = (q << 16) + ((r << 16) / a);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint predict_delta(longint od, longint nd);
        longint lo;
        longint hi;
        longint prev;
        longint sum;
        longint k;
        longint el;
        longint en;
        longint ev;
        longint res;
        int nl;
        int nn;
        int i1;
        int i2;
        bit hl;
        bit hn;
        bit take_leaf;
        clip = 1'b0;
        if (od == nd)
            return 0;
        nl   = eff_cnt(leaf_cnt);
        nn   = eff_cnt(node_cnt);
        lo   = (od < nd) ? od : nd;
        hi   = (od < nd) ? nd : od;
        i1   = count_ge(1'b1, nl, hi);
        i2   = count_ge(1'b0, nn, hi);
        k    = i1 - i2;
        prev = hi;
        sum  = 0;
        while (1)
        begin
            hl = i1 < nl;
            hn = i2 < nn;
            if (!hl && !hn)
                break;
            el = hl ? longint'(leaf_mem[i1]) : 0;
            en = hn ? longint'(node_mem[i2]) : 0;
            // ties go to the leaf
            take_leaf = hl && (!hn || el >= en);
            ev = take_leaf ? el : en;
            if (!(ev > lo))
                break;
            sum = add_clip(sum, mul_clip(k, prev - ev));
            if (take_leaf)
            begin
                k++;
                i1++;
            end
            else
            begin
                k--;
                i2++;
            end
            prev = ev;
        end
        sum = add_clip(sum, mul_clip(k, prev - lo));
        // moved younger: use the complement
        if (nd < od)
            res = sub_clip(hi - lo, sum);
        else
            res = sum;
        return scale_by_alpha(res);
    endfunction

    // ---------------- checker ----------------

    always @(posedge clk)
    begin
        delta_word_t w;
        if (rst_n && done)
        begin
            if (delta_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected word: delta %0d sat %0b",
                             $signed(prior_delta), saturated);
            end
            else
            begin
                w = delta_q.pop_front();
                if (prior_delta !== w.delta || saturated !== w.sat)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected delta %0d sat %0b, got %0d sat %0b",
                                 w.delta, w.sat, $signed(prior_delta), saturated);
                end
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_item(logic [1:0] m, int idx, longint ed, longint od, longint nd);
        delta_word_t w;
        date_t e;
        @(negedge clk);
        if ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start       = 1'b1;
        mode        = m;
        entry_index = IDX_W'(idx);
        entry_date  = date_t'(ed);
        old_date    = date_t'(od);
        new_date    = date_t'(nd);
        do
            @(posedge clk);
        while (busy);
        sent++;
        e = date_t'(ed);
        if (m == MODE_WR_LEAF)
            leaf_mem[idx] = e;
        else if (m == MODE_WR_NODE)
            node_mem[idx] = e;
        else if (m == MODE_QUERY)
        begin
            w.delta = predict_delta(longint'(date_t'(od)), longint'(date_t'(nd)));
            w.sat   = clip;
            delta_q = {delta_q, w};
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (delta_q.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_LEAF_COUNT)
            leaf_cnt = val[10:0];
        else if (idx == REG_NODE_COUNT)
            node_cnt = val[10:0];
        else if (idx == REG_ALPHA_SCALE)
            alpha_val = val;
    endtask

    function automatic longint rnd_date(bit wide);
        longint v;
        v = {$urandom, $urandom};
        if (wide)
            return longint'(date_t'(v));
        return longint'($signed(v[21:0]));
    endfunction

    task automatic query(longint od, longint nd);
        send_item(MODE_QUERY, $urandom_range(ENTRIES - 1), rnd_date(1), od, nd);
    endtask

    // fill entries 0..n-1 of both tables; style 0 narrow, 1 wide, 2 ties, 3 unsorted
    task automatic load_tables(int nl, int nn, int style);
        longint lv[$];
        longint nv[$];
        int i;
        for (i = 0; i < nl; i++)
            lv = {lv, rnd_date(style == 1)};
        for (i = 0; i < nn; i++)
            nv = {nv, ((style == 2 && nl > 0 && $urandom_range(1))
                       ? lv[$urandom_range(nl - 1)] : rnd_date(style == 1))};
        if (style == 3)
        begin
            lv.shuffle();
            nv.shuffle();
        end
        else
        begin
            lv.rsort();
            nv.rsort();
        end
        for (i = 0; i < nl; i++)
            send_item(MODE_WR_LEAF, i, lv[i], rnd_date(1), rnd_date(1));
        for (i = 0; i < nn; i++)
            send_item(MODE_WR_NODE, i, nv[i], rnd_date(1), rnd_date(1));
    endtask

    function automatic longint pick_date();
        int nl;
        int nn;
        longint v;
        nl = eff_cnt(leaf_cnt);
        nn = eff_cnt(node_cnt);
        case ($urandom_range(9))
            0, 1, 2:
                v = (nl > 0) ? longint'(leaf_mem[$urandom_range(nl - 1)]) : rnd_date(0);
            3, 4:
                v = (nn > 0) ? longint'(node_mem[$urandom_range(nn - 1)]) : rnd_date(0);
            5:
                v = rnd_date(1);
            default:
                v = rnd_date(0);
        endcase
        if ($urandom_range(4) == 0)
            v = v + $signed($urandom_range(2)) - 1;
        return longint'(date_t'(v));
    endfunction

    // ---------------- tests ----------------

    task automatic test_after_reset();
        query(0, 0);
        query(-(64'sd1 << 47), (64'sd1 << 47) - 1);
        query((64'sd1 << 47) - 1, -(64'sd1 << 47));
        query(64'sd5 << 16, 64'sd3 << 16);
    endtask

    task automatic test_directed();
        longint lv[6];
        longint nv[5];
        int i;
        lv = '{10, 8, 5, 5, 2, -1};
        nv = '{9, 5, 3, 0, -4};
        for (i = 0; i < 6; i++)
            send_item(MODE_WR_LEAF, i, lv[i] <<< 16, 0, 0);
        for (i = 0; i < 5; i++)
            send_item(MODE_WR_NODE, i, nv[i] <<< 16, 0, 0);
        cfg_write(REG_LEAF_COUNT, 6);
        cfg_write(REG_NODE_COUNT, 5);
        query(64'sd7 << 16, 64'sd4 << 16);
        query(64'sd4 << 16, 64'sd7 << 16);
        query(64'sd9 << 16, 64'sd5 << 16);      // event sits on the lower date
        query(64'sd5 << 16, 64'sd10 << 16);     // tie between tables on the lower date
        query(64'sd20 << 16, 64'sd12 << 16);    // above every event
        query(-(64'sd9 << 16), -(64'sd6 << 16)); // below every event
        query(64'sd30 << 16, -(64'sd30 << 16));
        query(64'sd3 << 16, 64'sd3 << 16);
        send_item(MODE_IGNORED, 0, 0, 1, 2);
        cfg_write(REG_ALPHA_SCALE, 0);
        query(-(64'sd1 << 47), (64'sd1 << 47) - 1);
        query(64'sd1, 0);
        cfg_write(REG_ALPHA_SCALE, 1);
        query((64'sd1 << 47) - 1, -(64'sd1 << 47));
        cfg_write(REG_ALPHA_SCALE, 48'hFFFF_FFFF_FFFF);
        query(64'sd10 << 16, -(64'sd2 << 16));
        cfg_write(REG_ALPHA_SCALE, 48'd3 << 15);
    endtask

    // full leaf table; counts above the table size clip to it
    task automatic test_full_tables();
        int j;
        load_tables(ENTRIES, NODE_FILL, 1);
        cfg_write(REG_LEAF_COUNT, ENTRIES);
        cfg_write(REG_NODE_COUNT, NODE_FILL);
        for (j = 0; j < 6; j++)
            query(pick_date(), pick_date());
        cfg_write(REG_LEAF_COUNT, 48'hFFFF_FFFF_FFFF);
        for (j = 0; j < 6; j++)
            query(pick_date(), pick_date());
    endtask

    task automatic test_random(int pct, int n_items);
        int first;
        int j;
        int nl;
        int nn;
        longint od;
        gap_pct = pct;
        first   = sent;
        while (sent - first < n_items)
        begin
            nl = $urandom_range(6);
            nn = $urandom_range(6);
            load_tables(nl, nn, $urandom_range(9) < 7 ? $urandom_range(2)
                                                        : $urandom_range(3));
            cfg_write(REG_LEAF_COUNT, ($urandom_range(9) == 0) ? 48'h7FF : nl);
            cfg_write(REG_NODE_COUNT, nn);
            case ($urandom_range(5))
                0: cfg_write(REG_ALPHA_SCALE, {$urandom, $urandom});
                1: cfg_write(REG_ALPHA_SCALE, $urandom_range(2));
                2: cfg_write(REG_ALPHA_SCALE, 48'hFFFF_FFFF_FFFF);
                default: cfg_write(REG_ALPHA_SCALE, $urandom_range(1 << 20, 1));
            endcase
            for (j = 0; j < 4; j++)
            begin
                od = pick_date();
                if ($urandom_range(15) == 0)
                    query(od, od);
                else
                    query(od, pick_date());
                if ($urandom_range(15) == 0)
                    send_item(MODE_IGNORED, $urandom_range(ENTRIES - 1), rnd_date(1),
                              rnd_date(1), rnd_date(1));
            end
        end
    endtask

    initial
    begin
        int w;
        rst_n       = 1'b0;
        start       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mode        = '0;
        entry_index = '0;
        entry_date  = '0;
        old_date    = '0;
        new_date    = '0;
        leaf_cnt    = '0;
        node_cnt    = '0;
        alpha_val   = ALPHA_RESET;
        gap_pct     = 0;
        errors      = 0;
        cycles      = 0;
        sent        = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_directed();
        test_full_tables();
        test_random(25, 75);
        test_random(84, 75);
        test_random(0, 75);

        @(negedge clk);
        start = 1'b0;
        w = 0;
        while (delta_q.size() != 0 && w < 20000)
        begin
            @(negedge clk);
            w++;
        end
        repeat (200) @(negedge clk);
        if (errors == 0 && delta_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/cpd_pkg.sv
rtl/cpd_ctrl.sv
rtl/cpd_dp.sv
rtl/coalescent_prior_delta_top.sv
rtl/cpd_checker.sv
tb/sv/testbench.sv
